FILE: sv/vt4_pkg.sv
// Shared types and constants for the 4x4 vector transform.
// No dependencies; imported by vt4_row and vector_transform_4x4_top.
package vt4_pkg;

   localparam int LANES          = 4;
   localparam int SLOT_BITS      = 16;
   localparam int ROW_BITS       = 64;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_ZERO  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_ONE   = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_TWO   = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_THREE = CSR_INDEX_BITS'(3);

   // Load enables, one per pipeline stage.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

FILE: sv/vt4_row.sv
// One matrix row dotted with the vector: multiply, pair add, sum and round,
// shift and saturate, one register stage each. Depends on vt4_pkg.
module vt4_row import vt4_pkg::*; #(
   parameter int VECTOR_BITS        = 24,
   parameter int COEF_BITS          = 16,
   parameter int COEF_FRACTION_BITS = 12
) (
   input  logic                          clock,
   input  stage_en_type                  stage_en,
   input  logic [ROW_BITS-1:0]           row,
   input  logic signed [VECTOR_BITS-1:0] vec [LANES],
   output logic signed [VECTOR_BITS-1:0] result,
   output logic                          clip
);

   localparam int PROD_BITS = VECTOR_BITS + COEF_BITS;
   localparam int PAIR_BITS = PROD_BITS + 1;
   localparam int ACC_BITS  = PROD_BITS + 2;

   localparam logic signed [ACC_BITS-1:0] HALF =
      ACC_BITS'((1 << COEF_FRACTION_BITS) >> 1);
   localparam logic signed [ACC_BITS-1:0] VMAX =
      {{(ACC_BITS-VECTOR_BITS+1){1'b0}}, {(VECTOR_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] VMIN =
      {{(ACC_BITS-VECTOR_BITS+1){1'b1}}, {(VECTOR_BITS-1){1'b0}}};

   logic signed [COEF_BITS-1:0]   coef     [LANES];
   logic signed [PROD_BITS-1:0]   prod_in  [LANES];
   logic signed [PROD_BITS-1:0]   prod_ff  [LANES];
   logic signed [PAIR_BITS-1:0]   pair_in  [2];
   logic signed [PAIR_BITS-1:0]   pair_ff  [2];
   logic signed [ACC_BITS-1:0]    acc_in;
   logic signed [ACC_BITS-1:0]    acc_ff;
   logic signed [ACC_BITS-1:0]    shifted;
   logic signed [VECTOR_BITS-1:0] result_in;
   logic signed [VECTOR_BITS-1:0] result_ff;
   logic                          clip_in;
   logic                          clip_ff;

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         // bits of a slot above the coefficient width are ignored
         coef[j]    = row[SLOT_BITS*j +: COEF_BITS];
         prod_in[j] = PROD_BITS'(coef[j]) * PROD_BITS'(vec[j]);
      end
      pair_in[0] = PAIR_BITS'(prod_ff[0]) + PAIR_BITS'(prod_ff[1]);
      pair_in[1] = PAIR_BITS'(prod_ff[2]) + PAIR_BITS'(prod_ff[3]);
      acc_in     = ACC_BITS'(pair_ff[0]) + ACC_BITS'(pair_ff[1]) + HALF;
      shifted    = acc_ff >>> COEF_FRACTION_BITS;
      priority if (shifted > VMAX) begin
         result_in = VMAX[VECTOR_BITS-1:0];
         clip_in   = 1'b1;
      end else if (shifted < VMIN) begin
         result_in = VMIN[VECTOR_BITS-1:0];
         clip_in   = 1'b1;
      end else begin
         result_in = shifted[VECTOR_BITS-1:0];
         clip_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         for (int j = 0; j < LANES; j++) begin
            prod_ff[j] <= prod_in[j];
         end
      end
      if (stage_en.s2) begin
         pair_ff[0] <= pair_in[0];
         pair_ff[1] <= pair_in[1];
      end
      if (stage_en.s3) begin
         acc_ff <= acc_in;
      end
      if (stage_en.s4) begin
         result_ff <= result_in;
         clip_ff   <= clip_in;
      end
   end

   assign result = result_ff;
   assign clip   = clip_ff;

endmodule

FILE: sv/vector_transform_4x4_top.sv
// Top level of the 4x4 matrix-vector transform: matrix registers, pipeline
// control and four vt4_row datapaths. Depends on vt4_pkg and vt4_row.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     req_in_x, req_in_y, req_in_z, req_in_w
//   rsp      out        rsp_valid / rsp_stall     rsp_out_x .. rsp_out_w, rsp_clipped
//   csr      in         csr_valid / csr_ready     csr_index, csr_data
//
// One transaction enters per cycle while req_stall is low; its result is offered
// after the multiply, pair add, sum-and-round and shift-and-saturate stages.
// Reset is synchronous and active high; it empties the pipeline and loads
// the identity matrix.
// A stall on rsp holds only the stages that are full up to the output;
// empty stages keep filling, so req stalls only when all four are full.
module vector_transform_4x4_top import vt4_pkg::*; #(
   parameter int VECTOR_BITS        = 24,
   parameter int COEF_BITS          = 16,
   parameter int COEF_FRACTION_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VECTOR_BITS-1:0] req_in_x,
   input  logic signed [VECTOR_BITS-1:0] req_in_y,
   input  logic signed [VECTOR_BITS-1:0] req_in_z,
   input  logic signed [VECTOR_BITS-1:0] req_in_w,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VECTOR_BITS-1:0] rsp_out_x,
   output logic signed [VECTOR_BITS-1:0] rsp_out_y,
   output logic signed [VECTOR_BITS-1:0] rsp_out_z,
   output logic signed [VECTOR_BITS-1:0] rsp_out_w,
   output logic                          rsp_clipped,
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [ROW_BITS-1:0]           csr_data
);

   localparam int STAGES = 4;

   // 1.0 in the coefficient format, dropped if it does not fit the width
   localparam logic [SLOT_BITS-1:0] ONE_SLOT =
      SLOT_BITS'((1 << COEF_FRACTION_BITS) & ((1 << COEF_BITS) - 1));

   logic [ROW_BITS-1:0]           rows_ff [LANES];
   logic [STAGES-1:0]             stage_valid_ff;
   logic [STAGES-1:0]             stage_valid_in;
   logic [STAGES-1:0]             stage_go;
   stage_en_type                  stage_en;
   logic signed [VECTOR_BITS-1:0] vec [LANES];
   logic signed [VECTOR_BITS-1:0] result [LANES];
   logic [LANES-1:0]              clip;

   // Registers are to be written only while idle; the block does not enforce this, so always take the write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            rows_ff[i] <= ROW_BITS'(ONE_SLOT) << (SLOT_BITS * i);
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ROW_ZERO:  rows_ff[0] <= csr_data;
            REG_ROW_ONE:   rows_ff[1] <= csr_data;
            REG_ROW_TWO:   rows_ff[2] <= csr_data;
            REG_ROW_THREE: rows_ff[3] <= csr_data;
            default: ;  // drop writes beyond the last row
         endcase
      end
   end

   // A stage loads when it is empty or the stage after it loads too;
   // the last stage frees up when its result is taken.
   always_comb begin
      stage_go[STAGES-1] = !stage_valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_go[k] = !stage_valid_ff[k] || stage_go[k+1];
      end
      stage_valid_in[0] = stage_go[0] ? req_valid : stage_valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         stage_valid_in[k] = stage_go[k] ? stage_valid_ff[k-1] : stage_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign stage_en.s1 = stage_go[0];
   assign stage_en.s2 = stage_go[1];
   assign stage_en.s3 = stage_go[2];
   assign stage_en.s4 = stage_go[3];

   assign req_stall = !stage_go[0];

   assign vec[0] = req_in_x;
   assign vec[1] = req_in_y;
   assign vec[2] = req_in_z;
   assign vec[3] = req_in_w;

   // One datapath per matrix row; all advance together on stage_en.
   for (genvar r = 0; r < LANES; r++) begin : g_row
      vt4_row #(
         .VECTOR_BITS        (VECTOR_BITS),
         .COEF_BITS          (COEF_BITS),
         .COEF_FRACTION_BITS (COEF_FRACTION_BITS)
      ) u_row (
         .clock    (clock),
         .stage_en (stage_en),
         .row      (rows_ff[r]),
         .vec      (vec),
         .result   (result[r]),
         .clip     (clip[r])
      );
   end

   assign rsp_valid   = stage_valid_ff[STAGES-1];
   assign rsp_out_x   = result[0];
   assign rsp_out_y   = result[1];
   assign rsp_out_z   = result[2];
   assign rsp_out_w   = result[3];
   assign rsp_clipped = |clip;

endmodule
